FILE: src/ntw_pkg.sv
package ntw_pkg;

    // Word codes.
    localparam logic [4:0] CODE_ZERO     = 5'd0;
    localparam logic [4:0] CODE_TEN      = 5'd10;
    localparam logic [4:0] CODE_TENS_OFS = 5'd18;
    localparam logic [4:0] CODE_HUNDRED  = 5'd28;
    localparam logic [4:0] CODE_THOUSAND = 5'd29;
    localparam logic [4:0] CODE_MILLION  = 5'd30;
    localparam logic [4:0] CODE_BILLION  = 5'd31;

    // Decimal digits held by the converter; ten cover any 32-bit value.
    localparam int NUM_DIGITS = 10;
    localparam int BCD_BITS   = NUM_DIGITS * 4;
    localparam int PC_BITS    = 5;

    // Group indexes.
    localparam logic [1:0] GRP_BILLIONS  = 2'd0;
    localparam logic [1:0] GRP_MILLIONS  = 2'd1;
    localparam logic [1:0] GRP_THOUSANDS = 2'd2;
    localparam logic [1:0] GRP_UNITS     = 2'd3;

    // Datapath operation of one step.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_NOP,
        OP_HUND,
        OP_HWORD,
        OP_TENS,
        OP_ONES,
        OP_SCALE,
        OP_ZERO
    } t_op;

    // Sequencing of one step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_JZ,
        C_WAIT_IN,
        C_WAIT_CV,
        C_FLUSH
    } t_cond;

    typedef struct packed {
        t_op                op;
        logic [1:0]         grp;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
    } t_cw;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_acc;
        logic conv_done;
        logic zero;
        logic stall;
    } t_flags;

    localparam logic [PC_BITS-1:0] PC_IDLE  = 5'd0;
    localparam logic [PC_BITS-1:0] PC_ZERO  = 5'd23;
    localparam logic [PC_BITS-1:0] PC_FLUSH = 5'd24;

    function automatic t_cw mk(t_op op, logic [1:0] grp, t_cond cond,
                               logic [PC_BITS-1:0] target);
        t_cw w;
        w.op     = op;
        w.grp    = grp;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Microcode store.
    function automatic t_cw ucode(logic [PC_BITS-1:0] pc);
        t_cw w;
        unique case (pc)
            5'd0:  w = mk(OP_IDLE,  GRP_BILLIONS,  C_WAIT_IN, PC_IDLE);
            5'd1:  w = mk(OP_NOP,   GRP_BILLIONS,  C_WAIT_CV, PC_IDLE);
            5'd2:  w = mk(OP_NOP,   GRP_BILLIONS,  C_JZ,      PC_ZERO);
            5'd3:  w = mk(OP_HUND,  GRP_BILLIONS,  C_NEXT,    PC_IDLE);
            5'd4:  w = mk(OP_HWORD, GRP_BILLIONS,  C_NEXT,    PC_IDLE);
            5'd5:  w = mk(OP_TENS,  GRP_BILLIONS,  C_NEXT,    PC_IDLE);
            5'd6:  w = mk(OP_ONES,  GRP_BILLIONS,  C_NEXT,    PC_IDLE);
            5'd7:  w = mk(OP_SCALE, GRP_BILLIONS,  C_NEXT,    PC_IDLE);
            5'd8:  w = mk(OP_HUND,  GRP_MILLIONS,  C_NEXT,    PC_IDLE);
            5'd9:  w = mk(OP_HWORD, GRP_MILLIONS,  C_NEXT,    PC_IDLE);
            5'd10: w = mk(OP_TENS,  GRP_MILLIONS,  C_NEXT,    PC_IDLE);
            5'd11: w = mk(OP_ONES,  GRP_MILLIONS,  C_NEXT,    PC_IDLE);
            5'd12: w = mk(OP_SCALE, GRP_MILLIONS,  C_NEXT,    PC_IDLE);
            5'd13: w = mk(OP_HUND,  GRP_THOUSANDS, C_NEXT,    PC_IDLE);
            5'd14: w = mk(OP_HWORD, GRP_THOUSANDS, C_NEXT,    PC_IDLE);
            5'd15: w = mk(OP_TENS,  GRP_THOUSANDS, C_NEXT,    PC_IDLE);
            5'd16: w = mk(OP_ONES,  GRP_THOUSANDS, C_NEXT,    PC_IDLE);
            5'd17: w = mk(OP_SCALE, GRP_THOUSANDS, C_NEXT,    PC_IDLE);
            5'd18: w = mk(OP_HUND,  GRP_UNITS,     C_NEXT,    PC_IDLE);
            5'd19: w = mk(OP_HWORD, GRP_UNITS,     C_NEXT,    PC_IDLE);
            5'd20: w = mk(OP_TENS,  GRP_UNITS,     C_NEXT,    PC_IDLE);
            5'd21: w = mk(OP_ONES,  GRP_UNITS,     C_NEXT,    PC_IDLE);
            5'd22: w = mk(OP_NOP,   GRP_UNITS,     C_JUMP,    PC_FLUSH);
            5'd23: w = mk(OP_ZERO,  GRP_UNITS,     C_NEXT,    PC_IDLE);
            5'd24: w = mk(OP_NOP,   GRP_UNITS,     C_FLUSH,   PC_IDLE);
            default: w = mk(OP_NOP, GRP_BILLIONS,  C_JUMP,    PC_IDLE);
        endcase
        return w;
    endfunction

    // Scale word spoken after a nonzero group.
    function automatic logic [4:0] scale_code(logic [1:0] grp);
        logic [4:0] c;
        unique case (grp)
            GRP_BILLIONS:  c = CODE_BILLION;
            GRP_MILLIONS:  c = CODE_MILLION;
            GRP_THOUSANDS: c = CODE_THOUSAND;
            GRP_UNITS:     c = CODE_ZERO;
        endcase
        return c;
    endfunction

endpackage

FILE: src/ntw_bcd.sv
module ntw_bcd #(
    parameter int VALUE_BITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic [ntw_pkg::BCD_BITS-1:0]  o_bcd,
    output logic                          o_done,
    output logic                          o_zero
);
    import ntw_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_BITS-1:0]   r_bcd;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_zero;
    logic [BCD_BITS-1:0]   w_adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    // Bit counter: one binary bit enters the decimal register each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_BITS'(VALUE_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Shift registers, most significant binary bit first.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin  <= i_value;
            r_bcd  <= '0;
            r_zero <= (i_value == '0);
        end else if (r_cnt != '0) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
        end
    end

    assign o_bcd  = r_bcd;
    assign o_done = (r_cnt == '0);
    assign o_zero = r_zero;

endmodule

FILE: src/ntw_useq.sv
module ntw_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ntw_pkg::t_flags i_flags,
    output ntw_pkg::t_cw    o_cw
);
    import ntw_pkg::*;

    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    t_cw                w_cw;

    assign w_cw = ucode(r_pc);
    assign o_cw = w_cw;

    // Next step: hold on a stall or an unmet wait, else branch or advance.
    always_comb begin
        n_pc = r_pc;
        if (!i_flags.stall) begin
            unique case (w_cw.cond)
                C_NEXT:    n_pc = r_pc + 1'b1;
                C_JUMP:    n_pc = w_cw.target;
                C_FLUSH:   n_pc = w_cw.target;
                C_JZ:      n_pc = i_flags.zero ? w_cw.target : r_pc + 1'b1;
                C_WAIT_IN: n_pc = i_flags.in_acc ? r_pc + 1'b1 : r_pc;
                C_WAIT_CV: n_pc = i_flags.conv_done ? r_pc + 1'b1 : r_pc;
                default:   n_pc = PC_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: src/number_to_word_tokens.sv
// Flow: an accepted number goes through bit-serial binary-to-decimal conversion,
// then 22 microcode steps or fewer; a stalled output holds the steps. A new number
// is taken only once the sequencer is back at its idle step, after the final word
// of the last number has moved to the output register.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the pending word and the output register.
module number_to_word_tokens #(
    parameter int VALUE_BITS = 31
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: value [VALUE_BITS-1:0], zero padding above
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: word_code [4:0], zero padding [7:5]
    output logic [7:0]                           m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tlast: last_word
    output logic                                 m_axis_tlast
);
    import ntw_pkg::*;

    t_cw                 w_cw;
    t_flags              w_flags;
    logic [BCD_BITS-1:0] w_bcd;
    logic                w_done;
    logic                w_zero;
    logic                w_in_acc;
    logic [3:0]          w_h;
    logic [3:0]          w_t;
    logic [3:0]          w_o;
    logic                w_emit;
    logic [4:0]          w_code;
    logic                w_flush;
    logic                w_out_free;
    logic                w_stall;
    logic                r_pend_vld;
    logic [4:0]          r_pend_code;
    logic                r_out_vld;
    logic [4:0]          r_out_code;
    logic                r_out_last;

    assign s_axis_tready = (w_cw.op == OP_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    ntw_bcd #(
        .VALUE_BITS (VALUE_BITS)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_in_acc),
        .i_value (s_axis_tdata[VALUE_BITS-1:0]),
        .o_bcd   (w_bcd),
        .o_done  (w_done),
        .o_zero  (w_zero)
    );

    assign w_flags.in_acc    = w_in_acc;
    assign w_flags.conv_done = w_done;
    assign w_flags.zero      = w_zero;
    assign w_flags.stall     = w_stall;

    ntw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_cw    (w_cw)
    );

    // Digits of the selected group; the billions group has only a ones digit.
    always_comb begin
        unique case (w_cw.grp)
            GRP_BILLIONS: begin
                w_h = 4'd0;
                w_t = 4'd0;
                w_o = w_bcd[36 +: 4];
            end
            GRP_MILLIONS: begin
                w_h = w_bcd[32 +: 4];
                w_t = w_bcd[28 +: 4];
                w_o = w_bcd[24 +: 4];
            end
            GRP_THOUSANDS: begin
                w_h = w_bcd[20 +: 4];
                w_t = w_bcd[16 +: 4];
                w_o = w_bcd[12 +: 4];
            end
            GRP_UNITS: begin
                w_h = w_bcd[8 +: 4];
                w_t = w_bcd[4 +: 4];
                w_o = w_bcd[0 +: 4];
            end
        endcase
    end

    // Word produced by the current step, if any.
    always_comb begin
        w_emit = 1'b0;
        w_code = CODE_ZERO;
        unique case (w_cw.op)
            OP_HUND: begin
                w_emit = (w_h != 4'd0);
                w_code = {1'b0, w_h};
            end
            OP_HWORD: begin
                w_emit = (w_h != 4'd0);
                w_code = CODE_HUNDRED;
            end
            OP_TENS: begin
                if (w_t >= 4'd2) begin
                    w_emit = 1'b1;
                    w_code = CODE_TENS_OFS + {1'b0, w_t};
                end else if (w_t == 4'd1) begin
                    w_emit = 1'b1;
                    w_code = CODE_TEN + {1'b0, w_o};
                end
            end
            OP_ONES: begin
                w_emit = (w_t != 4'd1) && (w_o != 4'd0);
                w_code = {1'b0, w_o};
            end
            OP_SCALE: begin
                w_emit = (w_h != 4'd0) || (w_t != 4'd0) || (w_o != 4'd0);
                w_code = scale_code(w_cw.grp);
            end
            OP_ZERO: begin
                w_emit = 1'b1;
                w_code = CODE_ZERO;
            end
            OP_IDLE, OP_NOP: begin
                w_emit = 1'b0;
            end
        endcase
    end

    // A word waits for a newer word or the end, so the final one can carry tlast.
    assign w_flush    = (w_cw.cond == C_FLUSH);
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_stall    = (w_emit || w_flush) && r_pend_vld && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (!w_stall) begin
            if (w_emit) begin
                r_pend_vld <= 1'b1;
            end else if (w_flush) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && w_emit) begin
            r_pend_code <= w_code;
        end
    end

    // Output register: a pending word moves here when a newer word or the end comes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((w_emit || w_flush) && r_pend_vld && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_emit || w_flush) && r_pend_vld && w_out_free) begin
            r_out_code <= r_pend_code;
            r_out_last <= w_flush;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out_code};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ntw_pkg::*;

    localparam int VALUE_BITS   = 31;
    localparam int TDATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_LIMIT   = 3000;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic [4:0] word_code;
        logic       last_word;
    } t_word;

    // Expected word sequence for every accepted number, checked in order.
    class word_scoreboard;
        t_word expected_words[$];
        int    numbers_noted;
        int    words_matched;
        int    errors;

        function void add_word(logic [4:0] word_code);
            t_word w;
            w.word_code = word_code;
            w.last_word = 1'b0;
            expected_words.push_back(w);
        endfunction

        // One group of 1..999: hundreds, then a teen or tens and ones.
        function void say_group(int unsigned grp_value);
            int unsigned hundreds;
            int unsigned rest;
            hundreds = grp_value / 100;
            rest     = grp_value % 100;
            if (hundreds != 0) begin
                add_word(5'(hundreds));
                add_word(CODE_HUNDRED);
            end
            if (rest >= 20) begin
                add_word(CODE_TENS_OFS + 5'(rest / 10));
                if (rest % 10 != 0)
                    add_word(5'(rest % 10));
            end else if (rest >= 10) begin
                add_word(CODE_TEN + 5'(rest - 10));
            end else if (rest != 0) begin
                add_word(5'(rest));
            end
        endfunction

        // Notes an accepted number; only the low VALUE_BITS bits count.
        function void note_number(logic [TDATA_BITS-1:0] tdata);
            int unsigned divisor [4] = '{1000000000, 1000000, 1000, 1};
            logic [4:0]  scale   [4] = '{CODE_BILLION, CODE_MILLION, CODE_THOUSAND, CODE_ZERO};
            int unsigned remaining;
            int unsigned grp_value;
            remaining = int'(tdata[VALUE_BITS-1:0]);
            numbers_noted++;
            if (remaining == 0) begin
                add_word(CODE_ZERO);
            end else begin
                for (int k = 0; k < 4; k++) begin
                    grp_value = remaining / divisor[k];
                    remaining = remaining % divisor[k];
                    if (grp_value != 0) begin
                        say_group(grp_value % 1000);
                        if (k < 3)
                            add_word(scale[k]);
                    end
                end
            end
            expected_words[expected_words.size()-1].last_word = 1'b1;
        endfunction

        function void check_word(logic [4:0] word_code, logic last_word);
            t_word want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, code %0d last %0b, nothing expected",
                         $time, word_code, last_word);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (want.word_code !== word_code || want.last_word !== last_word) begin
                    $display("%0t: word mismatch, expected code %0d last %0b, got code %0d last %0b",
                             $time, want.word_code, want.last_word, word_code, last_word);
                    errors++;
                end else begin
                    words_matched++;
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic [TDATA_BITS-1:0] s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  m_axis_tlast;

    word_scoreboard sb;
    bit             no_idle;
    bit             long_hold_req;
    int             idle_cycles = 0;
    int             directed_count;

    number_to_word_tokens #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // One three-digit group, biased toward zero, teens and round hundreds.
    function automatic int unsigned random_group();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: return 0;
            3:       return $urandom_range(10, 19);
            4:       return $urandom_range(1, 9) * 100;
            5:       return $urandom_range(1, 9) * 100 + $urandom_range(10, 19);
            default: return $urandom_range(1, 999);
        endcase
    endfunction

    function automatic logic [TDATA_BITS-1:0] random_number();
        longint unsigned total;
        logic [TDATA_BITS-1:0] tdata;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            tdata = TDATA_BITS'($urandom()) & TDATA_BITS'(VALUE_MAX);
        end else if (r < 30) begin
            tdata = TDATA_BITS'($urandom_range(0, 999));
        end else begin
            total = longint'($urandom_range(0, 2)) * 1000000000 +
                    longint'(random_group()) * 1000000 +
                    longint'(random_group()) * 1000 + longint'(random_group());
            if (total > longint'(VALUE_MAX))
                total = total - 1000000000;
            tdata = TDATA_BITS'(total);
        end
        // Now and then set the padding bit, which the block must ignore.
        if ($urandom_range(0, 19) == 0)
            tdata[TDATA_BITS-1] = 1'b1;
        return tdata;
    endfunction

    // Offers one number and waits for its transaction, then idles a while if the gap is nonzero.
    task automatic send_number(input logic [TDATA_BITS-1:0] tdata);
        int gap;
        @(negedge i_clk);
        s_axis_tdata  <= tdata;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        sb.note_number(tdata);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Output side: random ready with stalls, and one long hold-off on request.
    initial begin : word_sink
        int run;
        int stall;
        bit hold_done;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end
            run = $urandom_range(1, 12);
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat (run - 1) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Check every word transaction as it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata[4:0], m_axis_tlast);
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, giving up", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        logic [TDATA_BITS-1:0] directed [$];
        sb            = new();
        no_idle       = 1'b0;
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero, teens, tens, hundreds, scale boundaries, skipped groups, extremes.
        directed = '{0, 1, 9, 10, 15, 19, 20, 21, 99, 100, 101, 110, 999, 1000, 1001,
                     1000000, 1000000000, 1000000010, 1000001000, 700000017,
                     1234567891, 2000000000, TDATA_BITS'(VALUE_MAX)};
        // The padding bit alone, and above a small number.
        directed.push_back({1'b1, {(TDATA_BITS-1){1'b0}}});
        directed.push_back({1'b1, (TDATA_BITS-1)'(345)});
        directed_count = directed.size();
        foreach (directed[i])
            send_number(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Let the output stall for a long stretch while numbers keep coming.
            if (n == 40)
                long_hold_req = 1'b1;
            no_idle = (n >= 150 && n < 200);
            send_number(random_number());
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (sb.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Spoke %0d numbers (%0d directed, rest random), %0d word transactions matched.",
                 sb.numbers_noted, directed_count, sb.words_matched);
        $display("Output held off once for %0d cycles; %0d mismatches.",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
